// ===== rtl/core/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants and types for the decimal ASCII printer: digit widths,
// the reciprocal used for division by ten, and the records passed between
// the conversion front end, the digit queue and the character emitter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_W     = 16;
    localparam int CHAR_W      = 6;
    localparam int NUM_DIGITS  = 5;
    localparam int DIGIT_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam int IDX_W = $clog2(NUM_DIGITS);

    // x / 10 == (x * 52429) >> 19 holds exactly for every 16-bit x.
    localparam logic [VALUE_W-1:0] RECIP_DIV10 = 16'd52429;
    localparam int                 RECIP_SHIFT = 19;
    localparam int                 PROD_W      = 2 * VALUE_W;
    localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Digit i carries the weight 10**i.
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    typedef struct packed {
        logic    valid;
        digits_t digits;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/core/b2da_front.sv =====
// ----------------------------------------------------------------------------
// b2da_front
// Conversion front end. Splits an accepted value into five decimal digits,
// one division by ten per cycle, and pushes the digit record into the queue once it is not full.
// ----------------------------------------------------------------------------
module b2da_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [b2da_pkg::VALUE_W-1:0] value,
    input  b2da_pkg::queue_status_t      q_status,
    output logic                         busy,
    output b2da_pkg::push_t              push
);

    localparam int LOW_DIGITS = b2da_pkg::NUM_DIGITS - 2;
    localparam int STEP_W     = $clog2(LOW_DIGITS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LOW_DIGITS);

    logic                                           active_reg;
    logic [STEP_W-1:0]                              step_reg;
    logic [b2da_pkg::VALUE_W-1:0]                   work_reg;
    logic [LOW_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0]   low_digits_reg;

    logic [b2da_pkg::PROD_W-1:0]  prod;
    logic [b2da_pkg::QUOT_W-1:0]  quot;
    logic [b2da_pkg::VALUE_W-1:0] quot_ext;
    logic [b2da_pkg::VALUE_W-1:0] quot_x10;
    logic [b2da_pkg::VALUE_W-1:0] diff;
    logic [b2da_pkg::DIGIT_W-1:0] rem;
    logic                         last_step;
    logic                         accept;

    always_comb
    begin
        prod      = b2da_pkg::PROD_W'(work_reg) * b2da_pkg::PROD_W'(b2da_pkg::RECIP_DIV10);
        quot      = prod[b2da_pkg::PROD_W-1:b2da_pkg::RECIP_SHIFT];
        quot_ext  = b2da_pkg::VALUE_W'(quot);
        quot_x10  = (quot_ext << 3) + (quot_ext << 1);
        diff      = work_reg - quot_x10;
        rem       = diff[b2da_pkg::DIGIT_W-1:0];
        last_step = active_reg && (step_reg == LAST_STEP);

        push.valid  = last_step && !q_status.full;
        push.digits = {quot[b2da_pkg::DIGIT_W-1:0], rem, low_digits_reg};

        busy   = active_reg && !push.valid;
        accept = start && !busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            step_reg   <= '0;
        end
        else if (push.valid)
        begin
            active_reg <= 1'b0;
        end
        else if (active_reg && !last_step)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= value;
        end
        else if (active_reg && !last_step)
        begin
            work_reg                                        <= quot_ext;
            low_digits_reg[step_reg[$clog2(LOW_DIGITS)-1:0]] <= rem;
        end
    end

endmodule

// ===== rtl/core/b2da_queue.sv =====
// ----------------------------------------------------------------------------
// b2da_queue
// Short queue of digit records between the front end and the emitter, so
// that each side can stall without holding the other.
// ----------------------------------------------------------------------------
module b2da_queue
#(
    parameter int DEPTH = b2da_pkg::QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  b2da_pkg::push_t         push,
    input  logic                    pop,
    output b2da_pkg::digits_t       rd_digits,
    output b2da_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b2da_pkg::digits_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        status.full  = (count_reg == CNT_FULL);
        status.empty = (count_reg == '0);
        rd_digits    = mem[rd_ptr_reg];
        count_next   = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.digits;
        end
    end

endmodule

// ===== rtl/core/b2da_back.sv =====
// ----------------------------------------------------------------------------
// b2da_back
// Character emitter. Takes digit records from the queue, skips leading zeros
// and sends one ASCII character per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module b2da_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  b2da_pkg::queue_status_t     q_status,
    input  b2da_pkg::digits_t           rd_digits,
    output logic                        pop,
    output logic                        strobe,
    output logic [b2da_pkg::CHAR_W-1:0] digit_char,
    output logic                        last_digit
);

    logic                            active_reg;
    logic [b2da_pkg::IDX_W-1:0]      idx_reg;
    b2da_pkg::digits_t               cur_reg;
    logic                            strobe_reg;
    logic [b2da_pkg::CHAR_W-1:0]     char_reg;
    logic                            last_reg;
    logic [b2da_pkg::IDX_W-1:0]      first_idx;
    logic                            on_last;

    always_comb
    begin
        first_idx = '0;
        for (int i = 1; i < b2da_pkg::NUM_DIGITS; i++)
        begin
            if (rd_digits[i] != '0)
            begin
                first_idx = b2da_pkg::IDX_W'(i);
            end
        end
        on_last = (idx_reg == '0);
        pop     = (!active_reg || on_last) && !q_status.empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (pop)
            begin
                active_reg <= 1'b1;
                idx_reg    <= first_idx;
            end
            else if (active_reg)
            begin
                if (on_last)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= rd_digits;
        end
        if (active_reg)
        begin
            char_reg <= b2da_pkg::ASCII_ZERO
                        + b2da_pkg::CHAR_W'(cur_reg[idx_reg]);
            last_reg <= on_last;
        end
    end

    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

endmodule

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Prints a 16-bit unsigned value as decimal ASCII digits with leading zeros
// suppressed, one character per cycle, the last one flagged by last_digit.
// The first character passes through the front-end steps, the digit queue and
// the emitter registers. Four divide-by-ten steps in the front end and one
// character per cycle at the output set the rate at which values are taken.
// The receiver cannot stall; busy only reflects the front end and the queue.
// Reset clears all control state; no value is in flight afterwards.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
#(
    parameter int QUEUE_DEPTH = b2da_pkg::QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [b2da_pkg::VALUE_W-1:0] value,
    output logic                         strobe,
    output logic [b2da_pkg::CHAR_W-1:0]  digit_char,
    output logic                         last_digit
);

    b2da_pkg::push_t         push;
    b2da_pkg::queue_status_t q_status;
    b2da_pkg::digits_t       rd_digits;
    logic                    pop;

    b2da_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .value    (value),
        .q_status (q_status),
        .busy     (busy),
        .push     (push)
    );

    b2da_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .rd_digits (rd_digits),
        .status    (q_status)
    );

    b2da_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .rd_digits  (rd_digits),
        .pop        (pop),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    // A run of characters is never broken until its last digit.
    a_run_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_digit |=> strobe)
        else $error("character run broken before its last digit");

    // The first character of a run with more than one digit is never zero.
    a_no_leading_zero : assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_digit && (!$past(strobe) || $past(last_digit))
        |-> digit_char != b2da_pkg::ASCII_ZERO)
        else $error("leading zero emitted");

    // The front end never pushes into a full queue.
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_status.full)
        else $error("digit queue overflow");

    // The emitter never takes a record from an empty queue.
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("digit queue underflow");

endmodule

// ===== test/tb_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Sends 16-bit values to the decimal ASCII printer and checks every character
// it emits against a digit-by-digit prediction with leading zeros removed.
// Directed values cover the digit-count boundaries and extremes, then random
// values of every length follow under light, heavy and no sender idling.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [b2da_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } ascii_digit_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [b2da_pkg::VALUE_W-1:0]  value;
    logic                          strobe;
    logic [b2da_pkg::CHAR_W-1:0]   digit_char;
    logic                          last_digit;

    ascii_digit_t pending_chars[$];
    int           idle_pct;
    int           mismatches;
    int           values_sent;
    int           chars_checked;

    binary_to_decimal_ascii dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void predict_digits(input logic [b2da_pkg::VALUE_W-1:0] v);
        int           rest;
        int           digs[b2da_pkg::NUM_DIGITS];
        int           first;
        ascii_digit_t rec;
        rest  = int'(v);
        first = b2da_pkg::NUM_DIGITS - 1;
        for (int i = b2da_pkg::NUM_DIGITS - 1; i >= 0; i--)
        begin
            digs[i] = rest % 10;
            rest    = rest / 10;
        end
        for (int i = 0; i < b2da_pkg::NUM_DIGITS - 1; i++)
        begin
            if (digs[i] != 0)
            begin
                first = i;
                break;
            end
        end
        for (int i = first; i < b2da_pkg::NUM_DIGITS; i++)
        begin
            rec.ch   = b2da_pkg::CHAR_W'(digs[i]) + b2da_pkg::ASCII_ZERO;
            rec.last = (i == b2da_pkg::NUM_DIGITS - 1);
            pending_chars.push_back(rec);
        end
    endfunction

    function automatic logic [b2da_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return b2da_pkg::VALUE_W'($urandom_range(9));
            1: return b2da_pkg::VALUE_W'($urandom_range(99, 10));
            2: return b2da_pkg::VALUE_W'($urandom_range(999, 100));
            3: return b2da_pkg::VALUE_W'($urandom_range(9999, 1000));
            4: return b2da_pkg::VALUE_W'($urandom_range(65535, 10000));
            default: return b2da_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // Called right after a rising edge; returns at the edge of the transfer
    // with start still high, so a following call can continue without a gap.
    task automatic send_value(input logic [b2da_pkg::VALUE_W-1:0] v);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            value <= b2da_pkg::VALUE_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_digits(v);
        values_sent++;
    endtask

    task automatic test_directed();
        logic [b2da_pkg::VALUE_W-1:0] vals[$];
        vals = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
                 16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd10001, 16'd50000,
                 16'd32768, 16'd12345, 16'hAAAA, 16'h5555, 16'd10203, 16'd60909,
                 16'd0, 16'd65535};
        idle_pct = 15;
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    task automatic test_random(input int pct, input int count);
        idle_pct = pct;
        repeat (count)
            send_value(pick_value());
    endtask

    always @(posedge clk)
    begin
        ascii_digit_t exp;
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character transfer: digit_char %0d, last_digit %0b",
                       digit_char, last_digit);
                mismatches++;
            end
            else
            begin
                exp = pending_chars.pop_front();
                chars_checked++;
                if (digit_char !== exp.ch)
                begin
                    $error("digit_char: expected %0d, actual %0d", exp.ch, digit_char);
                    mismatches++;
                end
                if (last_digit !== exp.last)
                begin
                    $error("last_digit: expected %0b, actual %0b", exp.last, last_digit);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        mismatches    = 0;
        values_sent   = 0;
        chars_checked = 0;
        idle_pct      = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(15, 30);
        test_random(62, 30);
        test_random(0, 25);
        start <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d values of one to five digits, checked %0d characters.",
                 values_sent, chars_checked);
        $display("Sender idling went from light to heavy to none; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/b2da_pkg.sv
rtl/core/b2da_front.sv
rtl/core/b2da_queue.sv
rtl/core/b2da_back.sv
rtl/core/binary_to_decimal_ascii.sv
test/tb_binary_to_decimal_ascii.sv
